// ===== hdl/e2i_pkg.sv =====
// Shared constants, types and tables for the epoch to ISO 8601 timestamp block.
package e2i_pkg;

    localparam int EPOCH_W = 38;
    localparam int NSEC_W  = 30;
    localparam int CHAR_W  = 7;

    localparam logic [EPOCH_W-1:0] MAX_EPOCH = 38'd253402300799;
    localparam logic [NSEC_W-1:0]  MAX_NSEC  = 30'd999999999;

    // day split: (secs >> 7) / 675
    localparam int DAY_SH  = 7;
    localparam int DAY_DIV = 675;
    localparam int DAY_K   = 31;
    localparam int DAY_M   = 3181457;
    localparam int EPOCH_OFF = 719162 + 307;

    localparam int H_MUL  = 100;
    localparam int H_SUB  = 25;
    localparam int A_DIV  = 3652425;
    localparam int A_M    = 146;
    localparam int A_K    = 29;
    localparam int Y_DIV  = 36525;
    localparam int Y_M    = 14698;
    localparam int Y_K    = 29;
    localparam int DAYS_YR = 365;
    localparam int MO_MUL = 535;
    localparam int MO_ADD = 48950;
    localparam int MO_SH  = 14;
    localparam int DY_MUL = 979;
    localparam int DY_SUB = 2918;
    localparam int DY_SH  = 5;

    localparam int HR_DIV = 3600;
    localparam int HR_M   = 36;
    localparam int HR_K   = 17;
    localparam int MI_DIV = 60;
    localparam int MI_M   = 68;
    localparam int MI_K   = 12;

    localparam int NS_SCALE = 1000000000;
    localparam int N_DIG    = 14;
    localparam int N_STAGE  = 17;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_T     = 7'h54;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_DIGIT = 7'h00;

    localparam logic [4:0] POS_DOT  = 5'd19;
    localparam logic [4:0] POS_LAST = 5'd28;

    // fixed part of the text: separator or digit slot
    localparam logic [CHAR_W-1:0] FIXED_CHAR [0:18] = '{
        CH_DIGIT, CH_DIGIT, CH_DIGIT, CH_DIGIT, CH_DASH,
        CH_DIGIT, CH_DIGIT, CH_DASH, CH_DIGIT, CH_DIGIT, CH_T,
        CH_DIGIT, CH_DIGIT, CH_COLON, CH_DIGIT, CH_DIGIT, CH_COLON,
        CH_DIGIT, CH_DIGIT
    };
    localparam logic [3:0] DIG_IDX [0:18] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd0,
        4'd4, 4'd5, 4'd0, 4'd6, 4'd7, 4'd0,
        4'd8, 4'd9, 4'd0, 4'd10, 4'd11, 4'd0,
        4'd12, 4'd13
    };

    typedef struct packed {
        logic [N_DIG-1:0][3:0] dg;
        logic [NSEC_W-1:0]     ns;
    } dig_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] secs;
        logic [NSEC_W-1:0]  ns;
        logic [30:0]        x;
        logic [6:0]         lo7;
        logic [21:0]        q;
        logic [21:0]        r;
        logic [16:0]        tod;
        logic [28:0]        h;
        logic [6:0]         aq;
        logic [6:0]         a;
        logic [28:0]        num;
        logic [13:0]        year;
        logic [8:0]         c;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hh;
        logic [11:0]        remh;
        logic [5:0]         mm;
        logic [5:0]         ss;
        logic [3:0]         yth;
        logic [9:0]         yrem;
        logic [3:0]         yhu;
        logic [6:0]         y2;
        logic [N_DIG-1:0][3:0] dg;
    } pipe_t;

endpackage

// ===== hdl/e2i_stamp_if.sv =====
// Input channel: epoch seconds and nanosecond part.
interface e2i_stamp_if
    import e2i_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [EPOCH_W-1:0]  epoch_seconds;
    logic [NSEC_W-1:0]   nanosecond_part;

    modport source (output valid, epoch_seconds, nanosecond_part, input ready);
    modport sink   (input valid, epoch_seconds, nanosecond_part, output ready);
endinterface

// ===== hdl/e2i_text_if.sv =====
// Output channel: one ASCII character of the timestamp per item.
interface e2i_text_if
    import e2i_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  text_char;
    logic               last_char;

    modport source (output valid, text_char, last_char, input ready);
    modport sink   (input valid, text_char, last_char, output ready);
endinterface

// ===== hdl/e2i_calc.sv =====
// Calendar and time-of-day pipeline: epoch seconds to decimal digits.
module e2i_calc
    import e2i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    e2i_stamp_if.sink   stamp,
    output logic        dig_valid,
    input  logic        dig_ready,
    output dig_t        dig_data
);

    pipe_t              st_reg  [N_STAGE];
    pipe_t              st_next [N_STAGE];
    logic [N_STAGE-1:0] vld_reg;
    logic               en;

    function automatic logic [7:0] split2(input logic [6:0] v);
        logic [13:0] p;
        logic [3:0]  tn;
        p  = 14'(v) * 14'd103;
        tn = p[13:10];
        return {tn, 4'(7'(v) - 7'(tn) * 7'd10)};
    endfunction

    assign en          = !vld_reg[N_STAGE-1] || dig_ready;
    assign stamp.ready = en;
    assign dig_valid   = vld_reg[N_STAGE-1];
    assign dig_data.dg = st_reg[N_STAGE-1].dg;
    assign dig_data.ns = st_reg[N_STAGE-1].ns;

    always_comb
    begin
        logic [52:0] pd;
        logic [31:0] t32;
        logic [30:0] rem31;
        logic [21:0] p22;
        logic [16:0] t17;
        logic [16:0] rh;
        logic [36:0] pa;
        logic [28:0] ta;
        logic [28:0] ra;
        logic [6:0]  ac;
        logic [18:0] pm;
        logic [11:0] tm;
        logic [11:0] rmm;
        logic [42:0] py;
        logic [28:0] ty;
        logic [28:0] ry;
        logic [22:0] cw;
        logic [17:0] mw;
        logic [13:0] dw;
        logic [9:0]  dayw;
        logic [13:0] t14;
        logic [13:0] yrw;
        logic [13:0] p14;
        logic [9:0]  t10;
        logic [9:0]  r10;
        logic [7:0]  sp;

        // stage 0: clamp
        st_next[0]      = '0;
        st_next[0].secs = (stamp.epoch_seconds > MAX_EPOCH) ? MAX_EPOCH
                                                            : stamp.epoch_seconds;
        st_next[0].ns   = (stamp.nanosecond_part > MAX_NSEC) ? MAX_NSEC
                                                             : stamp.nanosecond_part;

        // stage 1: day estimate
        st_next[1]     = st_reg[0];
        st_next[1].x   = st_reg[0].secs[EPOCH_W-1:DAY_SH];
        st_next[1].lo7 = st_reg[0].secs[DAY_SH-1:0];
        pd             = 53'(st_next[1].x) * 53'(DAY_M);
        st_next[1].q   = pd[52:DAY_K];

        // stage 2: day correction, time of day
        st_next[2] = st_reg[1];
        t32        = 32'(st_reg[1].q) * 32'(DAY_DIV);
        rem31      = st_reg[1].x - t32[30:0];
        if (rem31 >= 31'(DAY_DIV))
        begin
            st_next[2].q = st_reg[1].q + 22'd1;
            rem31        = rem31 - 31'(DAY_DIV);
        end
        st_next[2].tod = {rem31[9:0], st_reg[1].lo7};
        st_next[2].r   = 22'(st_next[2].q + 22'(EPOCH_OFF));

        // stage 3: h, hour estimate
        st_next[3]    = st_reg[2];
        st_next[3].h  = 29'(29'(st_reg[2].r) * 29'(H_MUL) - 29'(H_SUB));
        p22           = 22'(st_reg[2].tod) * 22'(HR_M);
        st_next[3].hh = p22[21:HR_K];

        // stage 4: century estimate, hour correction
        st_next[4]    = st_reg[3];
        pa            = 37'(st_reg[3].h) * 37'(A_M);
        st_next[4].aq = pa[35:A_K];
        t17           = 17'(17'(st_reg[3].hh) * 17'(HR_DIV));
        rh            = st_reg[3].tod - t17;
        if (rh >= 17'(HR_DIV))
        begin
            st_next[4].hh = st_reg[3].hh + 5'd1;
            rh            = rh - 17'(HR_DIV);
        end
        st_next[4].remh = rh[11:0];

        // stage 5: century correction, minute estimate
        st_next[5] = st_reg[4];
        ta         = 29'(st_reg[4].aq) * 29'(A_DIV);
        ra         = st_reg[4].h - ta;
        ac         = (ra >= 29'(A_DIV)) ? st_reg[4].aq + 7'd1 : st_reg[4].aq;
        st_next[5].a  = ac - (ac >> 2);
        pm            = 19'(st_reg[4].remh) * 19'(MI_M);
        st_next[5].mm = pm[17:MI_K];

        // stage 6: year numerator, minute correction
        st_next[6]     = st_reg[5];
        st_next[6].num = 29'(st_reg[5].a) * 29'(H_MUL) + st_reg[5].h;
        tm             = 12'(12'(st_reg[5].mm) * 12'(MI_DIV));
        rmm            = st_reg[5].remh - tm;
        if (rmm >= 12'(MI_DIV))
        begin
            st_next[6].mm = st_reg[5].mm + 6'd1;
            rmm           = rmm - 12'(MI_DIV);
        end
        st_next[6].ss = rmm[5:0];

        // stage 7: year estimate
        st_next[7]      = st_reg[6];
        py              = 43'(st_reg[6].num) * 43'(Y_M);
        st_next[7].year = py[42:Y_K];

        // stage 8: year correction
        st_next[8] = st_reg[7];
        ty         = 29'(st_reg[7].year) * 29'(Y_DIV);
        ry         = st_reg[7].num - ty;
        if (ry >= 29'(Y_DIV))
            st_next[8].year = st_reg[7].year + 14'd1;

        // stage 9: day of year
        st_next[9]   = st_reg[8];
        cw           = 23'(st_reg[8].a) + 23'(st_reg[8].r)
                       - 23'(st_reg[8].year) * 23'(DAYS_YR)
                       - 23'(st_reg[8].year >> 2);
        st_next[9].c = cw[8:0];

        // stage 10: month
        st_next[10]       = st_reg[9];
        mw                = 18'(st_reg[9].c) * 18'(MO_MUL) + 18'(MO_ADD);
        st_next[10].month = mw[17:MO_SH];

        // stage 11: day of month, year wrap
        st_next[11]     = st_reg[10];
        dw              = 14'(st_reg[10].month) * 14'(DY_MUL) - 14'(DY_SUB);
        dayw            = 10'(st_reg[10].c) - 10'(dw >> DY_SH);
        st_next[11].day = dayw[4:0];
        if (st_reg[10].month > 4'd12)
        begin
            st_next[11].year  = st_reg[10].year + 14'd1;
            st_next[11].month = st_reg[10].month - 4'd12;
        end

        // stage 12: thousands estimate
        st_next[12]     = st_reg[11];
        st_next[12].yth = st_reg[11].year[13:10];

        // stage 13: thousands correction
        st_next[13] = st_reg[12];
        t14         = 14'(st_reg[12].yth) * 14'd1000;
        yrw         = st_reg[12].year - t14;
        if (yrw >= 14'd1000)
        begin
            st_next[13].yth = st_reg[12].yth + 4'd1;
            yrw             = yrw - 14'd1000;
        end
        st_next[13].yrem = yrw[9:0];

        // stage 14: hundreds estimate
        st_next[14]     = st_reg[13];
        p14             = 14'(st_reg[13].yrem) * 14'd10;
        st_next[14].yhu = p14[13:10];

        // stage 15: hundreds correction
        st_next[15] = st_reg[14];
        t10         = 10'(st_reg[14].yhu) * 10'd100;
        r10         = st_reg[14].yrem - t10;
        if (r10 >= 10'd100)
        begin
            st_next[15].yhu = st_reg[14].yhu + 4'd1;
            r10             = r10 - 10'd100;
        end
        st_next[15].y2 = r10[6:0];

        // stage 16: decimal digits
        st_next[16]       = st_reg[15];
        st_next[16].dg[0] = st_reg[15].yth;
        st_next[16].dg[1] = st_reg[15].yhu;
        sp                = split2(st_reg[15].y2);
        st_next[16].dg[2] = sp[7:4];
        st_next[16].dg[3] = sp[3:0];
        sp                = split2(7'(st_reg[15].month));
        st_next[16].dg[4] = sp[7:4];
        st_next[16].dg[5] = sp[3:0];
        sp                = split2(7'(st_reg[15].day));
        st_next[16].dg[6] = sp[7:4];
        st_next[16].dg[7] = sp[3:0];
        sp                = split2(7'(st_reg[15].hh));
        st_next[16].dg[8] = sp[7:4];
        st_next[16].dg[9] = sp[3:0];
        sp                = split2(7'(st_reg[15].mm));
        st_next[16].dg[10] = sp[7:4];
        st_next[16].dg[11] = sp[3:0];
        sp                = split2(7'(st_reg[15].ss));
        st_next[16].dg[12] = sp[7:4];
        st_next[16].dg[13] = sp[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N_STAGE; i++)
                st_reg[i] <= st_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N_STAGE-2:0], stamp.valid};
    end

endmodule

// ===== hdl/e2i_ser.sv =====
// Character serialiser: digits and fraction to ASCII text, one char per cycle while text does not stall.
module e2i_ser
    import e2i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  dig_t        up_data,
    e2i_text_if.source  text
);

    logic              busy_reg, busy_next;
    logic [4:0]        pos_reg, pos_next;
    dig_t              item_reg, item_next;
    logic [NSEC_W-1:0] frac_reg, frac_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic              adv;
    logic              emit;
    logic [33:0]       tu;
    logic [3:0]        fd;
    logic [NSEC_W-1:0] frac_rem;
    logic [CHAR_W-1:0] cur_char;
    logic              cur_last;

    assign text.valid     = out_valid_reg;
    assign text.text_char = char_reg;
    assign text.last_char = last_reg;

    always_comb
    begin
        adv  = !out_valid_reg || text.ready;
        emit = busy_reg && adv;

        // next fraction digit: floor(10u / 1e9)
        tu = 34'(frac_reg) * 34'd10;
        fd = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (tu >= 34'(k) * 34'(NS_SCALE))
                fd = 4'(k);
        end
        frac_rem = 30'(tu - 34'(fd) * 34'(NS_SCALE));

        if (pos_reg < POS_DOT)
        begin
            if (FIXED_CHAR[pos_reg] != CH_DIGIT)
                cur_char = FIXED_CHAR[pos_reg];
            else
                cur_char = CH_ZERO + 7'(item_reg.dg[DIG_IDX[pos_reg]]);
            cur_last = (pos_reg == POS_DOT - 5'd1) && (item_reg.ns == '0);
        end
        else if (pos_reg == POS_DOT)
        begin
            cur_char = CH_DOT;
            cur_last = 1'b0;
        end
        else
        begin
            cur_char = CH_ZERO + 7'(fd);
            cur_last = (frac_rem == '0);
        end

        up_ready = !busy_reg || (emit && cur_last);

        busy_next      = busy_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        frac_next      = frac_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = cur_char;
            last_next      = cur_last;
            pos_next       = pos_reg + 5'd1;
            if (pos_reg > POS_DOT)
                frac_next = frac_rem;
            if (cur_last)
                busy_next = 1'b0;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end

        if (up_valid && up_ready)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            item_next = up_data;
            frac_next = up_data.ns;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        frac_reg <= frac_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= POS_LAST))
        else $error("position past end of text");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> (busy_reg && pos_reg == '0))
        else $error("item load did not restart text");

    a_frac_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pos_reg == POS_LAST) |-> (frac_rem == '0))
        else $error("fraction longer than nine digits");

    a_plain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pos_reg == POS_DOT - 5'd1 && item_reg.ns == '0)
        |=> (out_valid_reg && last_reg))
        else $error("text without fraction not closed after seconds");

endmodule

// ===== hdl/epoch_to_iso8601_timestamp.sv =====
// Top level: Unix epoch seconds and nanoseconds to ISO 8601 text.
//
// stamp: one item per timestamp, epoch_seconds (clamped to 9999-12-31T23:59:59)
//        and nanosecond_part (clamped to 999999999).
// text:  one item per ASCII character of YYYY-MM-DDTHH:MM:SS[.fff...],
//        last_char set on the final character of each timestamp.
// A 17-stage calculation pipeline produces the decimal digits; the
// serialiser then emits one character per cycle while text does not stall,
// from a registered output. A timestamp has 19 characters without a
// fraction, 21 to 29 with one (fraction digits stop at the last nonzero
// digit); the serialiser sets the timestamp rate, and loads the next
// timestamp in the cycle of the last char.
// When text stalls, the serialiser holds, then the pipeline fills and
// stamp.ready drops; nothing is lost or repeated.
// Reset clears all valid flags; no item is in flight afterwards.
module epoch_to_iso8601_timestamp
    import e2i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    e2i_stamp_if.sink   stamp,
    e2i_text_if.source  text
);

    logic dig_valid;
    logic dig_ready;
    dig_t dig_data;

    e2i_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .stamp     (stamp),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig_data  (dig_data)
    );

    e2i_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dig_valid),
        .up_ready (dig_ready),
        .up_data  (dig_data),
        .text     (text)
    );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the epoch to ISO 8601 timestamp block: directed table, random items, predictor.
`timescale 1ns / 100ps
module testbench;
    import e2i_pkg::*;

    typedef struct {
        logic [EPOCH_W-1:0] secs;
        logic [NSEC_W-1:0]  ns;
        string              txt;
    } stim_row_t;

    logic clk;
    logic rst_n;
    e2i_stamp_if stamp ();
    e2i_text_if  text ();

    epoch_to_iso8601_timestamp u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp.sink),
        .text  (text.source)
    );

    logic [CHAR_W:0] char_queue [$];
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  stamps_sent;
    int  chars_seen;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void push_digit(input int v);
        char_queue.push_back({1'b0, CH_ZERO + 7'(v % 10)});
    endfunction

    function automatic void push_pair(input int v);
        push_digit(v / 10);
        push_digit(v);
    endfunction

    function automatic void push_sep(input logic [CHAR_W-1:0] ch);
        char_queue.push_back({1'b0, ch});
    endfunction

    // civil date formula on the clamped seconds, then digits and trimmed fraction
    function automatic void predict_text(input logic [EPOCH_W-1:0] s_in,
                                         input logic [NSEC_W-1:0] n_in);
        longint secs, days, r, h, a, yr, c, mo, dy, u, f;
        int tod;
        secs = (s_in > MAX_EPOCH) ? MAX_EPOCH : s_in;
        u    = (n_in > MAX_NSEC) ? MAX_NSEC : n_in;
        days = secs / 86400;
        tod  = int'(secs % 86400);
        r  = 719162 + days + 307;
        h  = 100 * r - 25;
        a  = h / 3652425;
        a  = a - (a >>> 2);
        yr = (100 * a + h) / 36525;
        c  = a + r - 365 * yr - (yr >>> 2);
        mo = (535 * c + 48950) >>> 14;
        dy = c - ((979 * mo - 2918) >>> 5);
        if (mo > 12)
        begin
            yr++;
            mo -= 12;
        end
        push_digit(int'(yr / 1000));
        push_digit(int'(yr / 100));
        push_pair(int'(yr % 100));
        push_sep(CH_DASH);
        push_pair(int'(mo));
        push_sep(CH_DASH);
        push_pair(int'(dy));
        push_sep(CH_T);
        push_pair(tod / 3600);
        push_sep(CH_COLON);
        push_pair((tod % 3600) / 60);
        push_sep(CH_COLON);
        push_pair(tod % 60);
        if (u != 0)
        begin
            f = 100000000;
            push_sep(CH_DOT);
            do
            begin
                push_digit(int'(u / f));
                u = u % f;
                f = f / 10;
            end while (u != 0 && f != 0);
        end
        char_queue[$][CHAR_W] = 1'b1;
    endfunction

    // valid stays high after acceptance; the next idle cycle or stop_sending drops it
    task automatic send_stamp(input logic [EPOCH_W-1:0] s, input logic [NSEC_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stamp.valid <= 1'b0;
            @(posedge clk);
        end
        stamp.valid           <= 1'b1;
        stamp.epoch_seconds   <= s;
        stamp.nanosecond_part <= n;
        predict_text(s, n);
        do
            @(posedge clk);
        while (!stamp.ready);
        stamps_sent++;
    endtask

    task automatic stop_sending();
        stamp.valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (char_queue.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                chars_seen++;
                if (char_queue.size() == 0)
                begin
                    $error("unexpected char %h", text.text_char);
                    errors++;
                end
                else
                begin
                    if (text.text_char !== char_queue[0][CHAR_W-1:0])
                    begin
                        $error("text_char exp %h got %h", char_queue[0][CHAR_W-1:0],
                               text.text_char);
                        errors++;
                    end
                    if (text.last_char !== char_queue[0][CHAR_W])
                    begin
                        $error("last_char exp %b got %b", char_queue[0][CHAR_W],
                               text.last_char);
                        errors++;
                    end
                    void'(char_queue.pop_front());
                end
            end
            text.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare the typed text of a directed row with the predictor's string
    task automatic check_row_text(input stim_row_t row);
        int i;
        logic [7:0] b;
        if (row.txt.len() == 0)
            return;
        for (i = 0; i < row.txt.len(); i++)
        begin
            b = row.txt[i];
            if (char_queue[char_queue.size() - row.txt.len() + i][CHAR_W-1:0]
                    !== b[CHAR_W-1:0])
            begin
                $error("typed text exp %s at %0d", row.txt, i);
                errors++;
            end
        end
    endtask

    stim_row_t rows [] = '{
        '{38'd0, 30'd0, "1970-01-01T00:00:00"},
        '{38'd0, 30'd1, "1970-01-01T00:00:00.000000001"},
        '{38'd253402300799, 30'd999999999, "9999-12-31T23:59:59.999999999"},
        '{38'h3F_FFFF_FFFF, 30'h3FFF_FFFF, "9999-12-31T23:59:59.999999999"},
        '{38'd253402300800, 30'd0, "9999-12-31T23:59:59"},
        '{38'd0, 30'd500000000, "1970-01-01T00:00:00.5"},
        '{38'd86399, 30'd0, "1970-01-01T23:59:59"},
        '{38'd951782400, 30'd0, "2000-02-29T00:00:00"},
        '{38'd951868800, 30'd0, "2000-03-01T00:00:00"},
        '{38'd4107456000, 30'd0, ""},
        '{38'd1709164800, 30'd120000000, ""},
        '{38'd946684799, 30'd100, ""},
        '{38'd2147483647, 30'd999999999, ""},
        '{38'd1000000000, 30'd123456789, ""},
        '{38'd1234567890, 30'd10, ""},
        '{38'h2A_AAAA_AAAA, 30'h1555_5555, ""},
        '{38'h15_5555_5555, 30'h2AAA_AAAA, ""}
    };

    task automatic send_random(input int count);
        int i;
        logic [EPOCH_W-1:0] s;
        logic [NSEC_W-1:0] n;
        for (i = 0; i < count; i++)
        begin
            s = EPOCH_W'({$urandom, $urandom} % 64'(MAX_EPOCH + 1));
            case ($urandom_range(9))
                0: s = EPOCH_W'({$urandom, $urandom});
                1: s = s % 38'd4000000000;
                default: ;
            endcase
            case ($urandom_range(5))
                0: n = '0;
                1: n = NSEC_W'($urandom);
                2: n = NSEC_W'(($urandom_range(9) + 1) * 100000000);
                default: n = NSEC_W'($urandom % (MAX_NSEC + 1));
            endcase
            send_stamp(s, n);
        end
    endtask

    initial
    begin
        int hold;
        errors = 0;
        stamps_sent = 0;
        chars_seen = 0;
        recv_hold = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 57;
        rst_n = 1'b0;
        stamp.valid = 1'b0;
        stamp.epoch_seconds = '0;
        stamp.nanosecond_part = '0;
        text.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send_stamp(rows[i].secs, rows[i].ns);
            check_row_text(rows[i]);
        end
        send_random(30);
        // long receiver stall while the sender keeps offering
        recv_hold <= 1'b1;
        fork
            begin
                send_random(24);
                stop_sending();
            end
            begin
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                recv_hold <= 1'b0;
            end
        join
        drain_all();
        send_idle_pct = 57;
        recv_idle_pct = 19;
        send_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(40);
        stop_sending();
        drain_all();
        repeat (40) @(posedge clk);
        $display("Sent %0d timestamps, checked %0d characters incl. clamping and fractions.",
                 stamps_sent, chars_seen);
        if (errors == 0 && char_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/e2i_pkg.sv
hdl/e2i_stamp_if.sv
hdl/e2i_text_if.sv
hdl/e2i_calc.sv
hdl/e2i_ser.sv
hdl/epoch_to_iso8601_timestamp.sv
tb/testbench.sv
